// File: sv/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared constants, opcodes and the control struct that the top level
// broadcasts to every cell of the recency chain.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   // Default build sizes.
   localparam int DEF_MAX_ENTRIES = 16;
   localparam int DEF_KEY_BITS    = 32;
   localparam int DEF_VALUE_BITS  = 32;

   // Capacity register layout.
   localparam int                 CAPACITY_BITS  = 5;
   localparam logic [CAPACITY_BITS-1:0] CAPACITY_RESET = 5'd16;

   // Request opcodes.
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // Control broadcast to all cells for one request.
   typedef struct packed {
      logic upd;       // the request changes the chain this cycle
      logic put_miss;  // every cell takes its neighbor's entry
   } cell_ctl_type;

endpackage

// File: sv/lkvc_cell.sv
// ----------------------------------------------------------------------------
// LRU key/value cache cell
// One position of the recency chain. Position 0 is the most recent entry.
// The cell compares its key with the request, passes the hit and read data
// along the chain, and takes its neighbor's entry when the chain shifts.
// ----------------------------------------------------------------------------
module lkvc_cell #(
   parameter int INDEX      = 0,
   parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS,
   parameter int CNT_W      = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lkvc_pkg::cell_ctl_type ctl,
   input  logic [KEY_BITS-1:0]    req_key,
   input  logic [CNT_W-1:0]       new_count,
   input  logic [KEY_BITS-1:0]    prev_key,
   input  logic [VALUE_BITS-1:0]  prev_value,
   input  logic                   found_in,
   input  logic [VALUE_BITS-1:0]  rd_in,
   output logic                   found_out,
   output logic [VALUE_BITS-1:0]  rd_out,
   output logic [KEY_BITS-1:0]    key_out,
   output logic [VALUE_BITS-1:0]  value_out
);
   import lkvc_pkg::*;

   logic                  valid_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  match;
   logic                  shift;

   // Compare against the request and extend the hit and read chains.
   always_comb begin
      match     = valid_ff && (key_ff == req_key);
      found_out = found_in | match;
      rd_out    = rd_in | (match ? value_ff : '0);
      // The cell shifts when the hit lies at or after it, or on a put miss.
      shift     = ctl.put_miss | found_out;
      key_out   = key_ff;
      value_out = value_ff;
   end

   // Valid entries are always the front of the chain, up to the new count.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.upd) begin
         valid_ff <= (new_count > CNT_W'(INDEX));
      end
   end

   // Entry payload moves one position toward the back on a shift.
   always_ff @(posedge clock) begin
      if (ctl.upd && shift) begin
         key_ff   <= prev_key;
         value_ff <= prev_value;
      end
   end

endmodule

// File: sv/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key/value store with least-recently-used replacement,
// kept as a chain of cells ordered from most to least recent.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): op selects get or put, with a key and a value.
//   Response channel (rsp_*): one response per request, in order. rsp_hit
//   tells whether the key was present before the request; rsp_read_value
//   carries the stored value on a get hit and zero otherwise.
//   CSR channel (csr_*): writes the capacity, the number of entries held
//   before eviction begins. Zero acts as one; values above MAX_ENTRIES act
//   as MAX_ENTRIES. Write it only while no request is outstanding.
//   Latency: a response appears in the cycle after its request is taken.
//   Throughput: one request per cycle while responses are taken. The
//   compare, read and shift across all cells happen in the accepting cycle,
//   so the chain length sets the combinational path.
//   Reset empties the cache and sets the capacity to 16.
//   When the receiver stalls, the response register holds its response and
//   req_ready drops until the response is taken.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
   parameter int MAX_ENTRIES = lkvc_pkg::DEF_MAX_ENTRIES,
   parameter int KEY_BITS    = lkvc_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS  = lkvc_pkg::DEF_VALUE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic signed [KEY_BITS-1:0]           req_key,
   input  logic signed [VALUE_BITS-1:0]         req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_hit,
   output logic signed [VALUE_BITS-1:0]         rsp_read_value,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lkvc_pkg::CAPACITY_BITS-1:0]   csr_capacity
);
   import lkvc_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int LIM_W = (CNT_W > CAPACITY_BITS) ? CNT_W : CAPACITY_BITS;

   logic [CAPACITY_BITS-1:0] capacity_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_hit_ff;
   logic [VALUE_BITS-1:0]    rsp_read_value_ff;

   logic                     req_fire;
   logic                     hit;
   logic [LIM_W-1:0]         cap_ext;
   logic [LIM_W-1:0]         limit;
   logic [LIM_W-1:0]         cnt_ext;
   logic [LIM_W-1:0]         cnt_next_ext;
   logic [VALUE_BITS-1:0]    front_value;
   cell_ctl_type             ctl;

   logic [KEY_BITS-1:0]      key_c   [MAX_ENTRIES];
   logic [VALUE_BITS-1:0]    value_c [MAX_ENTRIES];
   logic [MAX_ENTRIES:0]     found_c;
   logic [VALUE_BITS-1:0]    rd_c    [MAX_ENTRIES+1];

   // Handshakes.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_valid) begin
         capacity_ff <= csr_capacity;
      end
   end

   // Chain ends: nothing found past the last cell.
   assign found_c[MAX_ENTRIES] = 1'b0;
   assign rd_c[MAX_ENTRIES]    = '0;
   assign hit                  = found_c[0];

   // Front entry: the request key, with the new value on a put or the
   // stored value when a get hit moves its entry to the front.
   assign front_value = (req_op == OP_PUT) ? VALUE_BITS'(req_value) : rd_c[0];

   // Effective limit and the entry count after this request.
   always_comb begin
      cap_ext = LIM_W'(capacity_ff);
      cnt_ext = LIM_W'(count_ff);
      if (cap_ext == '0) begin
         limit = LIM_W'(1);
      end else if (cap_ext > LIM_W'(MAX_ENTRIES)) begin
         limit = LIM_W'(MAX_ENTRIES);
      end else begin
         limit = cap_ext;
      end

      ctl.upd      = req_fire && ((req_op == OP_PUT) || hit);
      ctl.put_miss = (req_op == OP_PUT) && !hit;

      priority if (req_op == OP_GET) begin
         cnt_next_ext = cnt_ext;
      end else if (hit) begin
         // The old entry is dropped; evict one more only when still full.
         cnt_next_ext = ((cnt_ext - LIM_W'(1)) >= limit) ? cnt_ext - LIM_W'(1) : cnt_ext;
      end else begin
         // A new key grows the count only below the limit.
         cnt_next_ext = (cnt_ext >= limit) ? cnt_ext : cnt_ext + LIM_W'(1);
      end
      count_in = CNT_W'(cnt_next_ext);
   end

   // Entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.upd) begin
         count_ff <= count_in;
      end
   end

   // Recency chain, most recent entry in cell 0.
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [KEY_BITS-1:0]   prev_key;
      logic [VALUE_BITS-1:0] prev_value;

      if (i == 0) begin : g_front
         assign prev_key   = KEY_BITS'(req_key);
         assign prev_value = front_value;
      end else begin : g_inner
         assign prev_key   = key_c[i-1];
         assign prev_value = value_c[i-1];
      end

      lkvc_cell #(
         .INDEX      (i),
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .req_key    (KEY_BITS'(req_key)),
         .new_count  (count_in),
         .prev_key   (prev_key),
         .prev_value (prev_value),
         .found_in   (found_c[i+1]),
         .rd_in      (rd_c[i+1]),
         .found_out  (found_c[i]),
         .rd_out     (rd_c[i]),
         .key_out    (key_c[i]),
         .value_out  (value_c[i])
      );
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_hit_ff        <= hit;
         rsp_read_value_ff <= (req_op == OP_GET) ? rd_c[0] : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_read_value_ff;

`ifndef ASSERT_OFF
   // The count never exceeds the number of built cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above built depth");

   // A get leaves the count as it was.
   a_get_count: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_op == OP_GET) |=> $stable(count_ff))
      else $error("get changed the entry count");

   // After a put the cache holds at least one entry.
   a_put_nonempty: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_op == OP_PUT) |=> (count_ff != '0))
      else $error("cache empty after put");

   // At or above the limit the count does not grow.
   a_no_growth: assert property (@(posedge clock) disable iff (reset)
      req_fire && (cnt_ext >= limit) |=> (count_ff <= $past(count_ff)))
      else $error("entry count grew past the limit");
`endif

endmodule

// File: tb/sv/lru_key_value_cache_tb.sv
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Drives get and put requests into the cache and checks every response
// against a predictor that keeps its own copy of the entries and their
// recency order. Directed requests cover key and value extremes, updates,
// misses and the capacity corner cases. Random phases follow, each with its
// own capacity, key pool and amount of sender idling and receiver stalling.
// One test holds the response channel off for a long stretch.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lkvc_pkg::*;

   localparam int DEPTH  = DEF_MAX_ENTRIES;
   localparam int KBITS  = DEF_KEY_BITS;
   localparam int VBITS  = DEF_VALUE_BITS;

   // One expected response.
   typedef struct {
      logic             hit;
      logic [VBITS-1:0] read_value;
   } lookup_result_type;

   // Clock, reset and block ports.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid      = 1'b0;
   logic                      req_ready;
   logic                      req_op         = OP_GET;
   logic [KBITS-1:0]          req_key        = '0;
   logic [VBITS-1:0]          req_value      = '0;
   logic                      rsp_valid;
   logic                      rsp_ready      = 1'b0;
   logic                      rsp_hit;
   logic [VBITS-1:0]          rsp_read_value;
   logic                      csr_valid      = 1'b0;
   logic                      csr_ready;
   logic [CAPACITY_BITS-1:0]  csr_capacity   = '0;

   // Predictor state: a shadow copy of the cache contents.
   logic [KBITS-1:0]          shadow_key   [DEPTH];
   logic [VBITS-1:0]          shadow_value [DEPTH];
   bit                        shadow_used  [DEPTH];
   int unsigned               shadow_age   [DEPTH];
   int unsigned               shadow_fill;
   logic [CAPACITY_BITS-1:0]  shadow_capacity;

   // Scoreboard and run statistics.
   lookup_result_type         pending_lookups[$];
   logic [KBITS-1:0]          key_pool[$];
   int                        sent_count     = 0;
   int                        checked_count  = 0;
   int                        hit_count      = 0;
   int                        mismatch_count = 0;

   // Traffic shaping: idle and stall chances in percent of cycles, hold in cycles.
   int                        idle_pct    = 0;
   int                        stall_pct   = 0;
   int                        hold_cycles = 0;

   always #1 clock = ~clock;

   lru_key_value_cache DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_capacity   (csr_capacity)
   );

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Empty the shadow cache and restore the reset capacity.
   function automatic void clear_shadow();
      for (int j = 0; j < DEPTH; j++) begin
         shadow_used[j]  = 1'b0;
         shadow_age[j]   = 0;
         shadow_key[j]   = '0;
         shadow_value[j] = '0;
      end
      shadow_fill     = 0;
      shadow_capacity = CAPACITY_RESET;
   endfunction

   // Remove one entry and close the gap in the recency order behind it.
   function automatic void retire_entry(int slot);
      int unsigned rank;
      rank = shadow_age[slot];
      shadow_used[slot] = 1'b0;
      shadow_age[slot]  = 0;
      for (int j = 0; j < DEPTH; j++) begin
         if (shadow_used[j] && shadow_age[j] > rank) shadow_age[j]--;
      end
      if (shadow_fill > 0) shadow_fill--;
   endfunction

   // Apply one request to the shadow cache and return its response.
   function automatic lookup_result_type apply_request(logic op, logic [KBITS-1:0] key,
                                                       logic [VBITS-1:0] value);
      lookup_result_type res;
      int             found;
      int             oldest;
      int             free_slot;
      int unsigned    limit;
      res.hit        = 1'b0;
      res.read_value = '0;
      found          = -1;
      for (int j = 0; j < DEPTH; j++) begin
         if (found < 0 && shadow_used[j] && shadow_key[j] == key) found = j;
      end
      res.hit = (found >= 0);

      if (op == OP_GET) begin
         // A get hit returns the value and moves the entry to the front.
         if (res.hit) begin
            res.read_value = shadow_value[found];
            for (int j = 0; j < DEPTH; j++) begin
               if (shadow_used[j] && shadow_age[j] < shadow_age[found]) shadow_age[j]++;
            end
            shadow_age[found] = 0;
         end
      end else begin
         // A put drops any old copy, evicts if full, then inserts at the front.
         if (res.hit) retire_entry(found);
         limit = (shadow_capacity == 0) ? 1 :
                 (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
         if (shadow_fill >= limit) begin
            oldest = -1;
            for (int j = 0; j < DEPTH; j++) begin
               if (shadow_used[j] && (oldest < 0 || shadow_age[j] > shadow_age[oldest]))
                  oldest = j;
            end
            if (oldest >= 0) retire_entry(oldest);
         end
         free_slot = -1;
         for (int j = 0; j < DEPTH; j++) begin
            if (shadow_used[j]) shadow_age[j]++;
            else if (free_slot < 0) free_slot = j;
         end
         if (free_slot >= 0) begin
            shadow_used[free_slot]  = 1'b1;
            shadow_key[free_slot]   = key;
            shadow_value[free_slot] = value;
            shadow_age[free_slot]   = 0;
            shadow_fill++;
         end
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   function automatic void log_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   // Compare each response with the oldest expectation, then record new requests.
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            checked_count++;
            if (rsp_hit) hit_count++;
            if (pending_lookups.size() == 0) begin
               log_mismatch($sformatf("response with none expected: hit=%0b value=%h",
                                      rsp_hit, rsp_read_value));
            end else begin
               want = pending_lookups.pop_front();
               if (rsp_hit !== want.hit)
                  log_mismatch($sformatf("hit: expected %0b, got %0b", want.hit, rsp_hit));
               if (rsp_read_value !== want.read_value)
                  log_mismatch($sformatf("read_value: expected %h, got %h",
                                         want.read_value, rsp_read_value));
            end
         end
         if (req_valid && req_ready)
            pending_lookups.push_back(apply_request(req_op, req_key, req_value));
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold when a test asks for one.
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender and shared tasks
   // ------------------------------------------------------------------------

   // Offer one request, with a possible random gap first, and wait until it is taken.
   task automatic send_request(logic op, logic [KBITS-1:0] key, logic [VBITS-1:0] value);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_key   <= key;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // Stop offering and wait until every response has been checked.
   task automatic drain_requests();
      req_valid <= 1'b0;
      wait (checked_count == sent_count);
      repeat (3) @(posedge clock);
   endtask

   // Write the capacity register while the cache is idle.
   task automatic write_capacity(logic [CAPACITY_BITS-1:0] cap);
      drain_requests();
      csr_valid    <= 1'b1;
      csr_capacity <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_capacity = cap;
   endtask

   // Pick a key: mostly from the current pool so that hits and evictions happen.
   function automatic logic [KBITS-1:0] pick_key();
      if (key_pool.size() > 0 && $urandom_range(99) < 85)
         return key_pool[$urandom_range(key_pool.size() - 1)];
      return $urandom;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Extreme keys and values, hits, misses and an update of a present key.
   task automatic test_directed_basics();
      idle_pct  = 0;
      stall_pct = 0;
      send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      // Updating a present key reports a hit with a zero value.
      send_request(OP_PUT, 32'h0000_0000, 32'h1234_5678);
      send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_GET, 32'h0000_0001, 32'h0000_0000);
      drain_requests();
   endtask

   // Capacity of one, zero (acts as one), saturation, and lowering below the fill.
   task automatic test_capacity_corners();
      write_capacity(5'd1);
      send_request(OP_PUT, 32'h0000_00A0, 32'h0000_0001);
      send_request(OP_PUT, 32'h0000_00B0, 32'h0000_0002);
      send_request(OP_GET, 32'h0000_00A0, 32'h0000_0000);
      send_request(OP_GET, 32'h0000_00B0, 32'h0000_0000);
      write_capacity(5'd0);
      send_request(OP_PUT, 32'h0000_00C0, 32'h0000_0003);
      send_request(OP_PUT, 32'h0000_00D0, 32'h0000_0004);
      send_request(OP_GET, 32'h0000_00D0, 32'h0000_0000);
      write_capacity(5'd31);
      send_request(OP_PUT, 32'h0000_00E0, 32'h0000_0005);
      send_request(OP_PUT, 32'h0000_00F0, 32'h0000_0006);
      send_request(OP_PUT, 32'h0000_0100, 32'h0000_0007);
      // The held entries stay; each later put evicts before it inserts.
      write_capacity(5'd2);
      send_request(OP_PUT, 32'h0000_0110, 32'h0000_0008);
      send_request(OP_GET, 32'h0000_00D0, 32'h0000_0000);
      send_request(OP_PUT, 32'h0000_0120, 32'h0000_0009);
      send_request(OP_GET, 32'h0000_00E0, 32'h0000_0000);
      drain_requests();
   endtask

   // Random gets and puts over a key pool sized around the capacity.
   task automatic test_random_traffic(logic [CAPACITY_BITS-1:0] cap, int idle, int stall,
                                      int pool_size, int count);
      write_capacity(cap);
      idle_pct  = idle;
      stall_pct = stall;
      key_pool.delete();
      key_pool.push_back(32'h8000_0000);
      key_pool.push_back(32'h7FFF_FFFF);
      while (key_pool.size() < pool_size) key_pool.push_back($urandom);
      for (int i = 0; i < count; i++)
         send_request($urandom_range(1) ? OP_PUT : OP_GET, pick_key(), $urandom);
      drain_requests();
   endtask

   // Hold responses off for a long stretch while requests keep coming.
   task automatic test_response_hold();
      idle_pct    = 0;
      stall_pct   = 0;
      hold_cycles = 60;
      for (int i = 0; i < 24; i++)
         send_request($urandom_range(1) ? OP_PUT : OP_GET, pick_key(), $urandom);
      drain_requests();
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      clear_shadow();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_basics();
      test_capacity_corners();
      test_random_traffic(5'd16, 0, 0, 20, 120);
      test_random_traffic(5'd3, 45, 0, 6, 110);
      test_random_traffic(5'd31, 0, 45, 24, 120);
      test_random_traffic(5'd1, 33, 33, 3, 100);
      test_response_hold();
      test_random_traffic(5'd8, 0, 0, 12, 110);
      test_random_traffic(5'd0, 33, 33, 2, 60);
      test_random_traffic(5'($urandom_range(31)), 45, 45, 16, 80);

      drain_requests();
      $display("Checked %0d responses to %0d requests, %0d of them hits.",
               checked_count, sent_count, hit_count);
      $display("Capacities 0 to 31 with idle, stall and long-hold phases; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0 && pending_lookups.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #400_000;
      $display("Timeout with %0d of %0d responses checked.", checked_count, sent_count);
      $display("simulation failed");
      $finish;
   end

endmodule

// File: files.f
sv/lkvc_pkg.sv
sv/lkvc_cell.sv
sv/lru_key_value_cache.sv
tb/sv/lru_key_value_cache_tb.sv
